// File: hw/rtl/ps2kc_pkg.sv
`default_nettype none
package ps2kc_pkg;

   // bus request codes
   typedef enum logic [2:0] {
      REQ_RD_DATA   = 3'd0,
      REQ_RD_STATUS = 3'd1,
      REQ_WR_DATA   = 3'd2,
      REQ_WR_CMD    = 3'd3,
      REQ_INJECT    = 3'd4
   } req_code_type;

   // operation class handed from the front to the back
   typedef enum logic [2:0] {
      OP_NOP,
      OP_RD_DATA,
      OP_RD_STATUS,
      OP_WR_DATA,
      OP_WR_CMD,
      OP_INJECT
   } op_kind_type;

   // controller command classes
   typedef enum logic [3:0] {
      CC_IGNORE,
      CC_RD_CFG,
      CC_WR_CFG,
      CC_SELF_TEST,
      CC_PORT_TEST,
      CC_SET_KBD_DIS,
      CC_CLR_KBD_DIS,
      CC_SET_AUX_DIS,
      CC_CLR_AUX_DIS,
      CC_RD_INPORT,
      CC_RD_OUTPORT,
      CC_WR_OUTPORT,
      CC_WR_AUX
   } cmd_class_type;

   // keyboard command classes
   typedef enum logic [2:0] {
      KC_OTHER,
      KC_RESET,
      KC_IDENT,
      KC_ECHO,
      KC_PARAM
   } kbd_class_type;

   // controller command waiting for a data byte
   typedef enum logic [1:0] {
      PEND_NONE    = 2'd0,
      PEND_CFG     = 2'd1,
      PEND_OUTPORT = 2'd2,
      PEND_AUX     = 2'd3
   } pend_kind_type;

   typedef struct packed {
      op_kind_type   kind;
      cmd_class_type cmd;
      kbd_class_type kbd;
      logic [7:0]    data_byte;
      logic [7:0]    second_byte;
   } op_type;

   // controller command codes
   localparam logic [7:0] CMD_RD_CFG_LO   = 8'h20;
   localparam logic [7:0] CMD_RD_CFG_HI   = 8'h3F;
   localparam logic [7:0] CMD_WR_CFG_LO   = 8'h60;
   localparam logic [7:0] CMD_WR_CFG_HI   = 8'h7F;
   localparam logic [7:0] CMD_SELF_TEST   = 8'hAA;
   localparam logic [7:0] CMD_KBD_TEST    = 8'hAB;
   localparam logic [7:0] CMD_AUX_TEST    = 8'hA9;
   localparam logic [7:0] CMD_KBD_DISABLE = 8'hAD;
   localparam logic [7:0] CMD_KBD_ENABLE  = 8'hAE;
   localparam logic [7:0] CMD_AUX_DISABLE = 8'hA7;
   localparam logic [7:0] CMD_AUX_ENABLE  = 8'hA8;
   localparam logic [7:0] CMD_RD_INPORT   = 8'hC0;
   localparam logic [7:0] CMD_RD_OUTPORT  = 8'hD0;
   localparam logic [7:0] CMD_WR_OUTPORT  = 8'hD1;
   localparam logic [7:0] CMD_WR_AUX      = 8'hD4;

   // keyboard command codes
   localparam logic [7:0] KBD_CODE_RESET   = 8'hFF;
   localparam logic [7:0] KBD_CODE_IDENT   = 8'hF2;
   localparam logic [7:0] KBD_CODE_ECHO    = 8'hEE;
   localparam logic [7:0] KBD_CODE_LEDS    = 8'hED;
   localparam logic [7:0] KBD_CODE_RATE    = 8'hF3;
   localparam logic [7:0] KBD_CODE_SCANSET = 8'hF0;

   // response bytes and reset values
   localparam logic [7:0] RESP_ACK       = 8'hFA;
   localparam logic [7:0] RESP_BAT_OK    = 8'hAA;
   localparam logic [7:0] RESP_ID_0      = 8'hAB;
   localparam logic [7:0] RESP_ID_1      = 8'h83;
   localparam logic [7:0] RESP_ECHO      = 8'hEE;
   localparam logic [7:0] RESP_SELF_TEST = 8'h55;
   localparam logic [7:0] RESP_PORT_OK   = 8'h00;
   localparam logic [7:0] RESP_INPORT    = 8'hBF;
   localparam logic [7:0] STATUS_BASE    = 8'h14;
   localparam logic [7:0] CFG_RESET      = 8'h47;
   localparam logic [7:0] OUTPORT_RESET  = 8'hCF;
   localparam logic [7:0] CFG_KBD_DIS    = 8'h10;
   localparam logic [7:0] CFG_AUX_DIS    = 8'h20;

endpackage
`default_nettype wire

// File: hw/rtl/ps2kc_front.sv
`default_nettype none
module ps2kc_front
   import ps2kc_pkg::*;
(
   input  wire logic [2:0] req_type,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [7:0] req_second_byte,
   output op_type          op
);

   // classify the request, the command byte and the keyboard byte
   always_comb begin
      op.kind        = OP_NOP;
      op.cmd         = CC_IGNORE;
      op.kbd         = KC_OTHER;
      op.data_byte   = req_data_byte;
      op.second_byte = req_second_byte;

      case (req_type)
         REQ_RD_DATA:   op.kind = OP_RD_DATA;
         REQ_RD_STATUS: op.kind = OP_RD_STATUS;
         REQ_WR_DATA:   op.kind = OP_WR_DATA;
         REQ_WR_CMD:    op.kind = OP_WR_CMD;
         REQ_INJECT:    op.kind = OP_INJECT;
         default:       op.kind = OP_NOP;
      endcase

      // controller command class
      if (req_data_byte >= CMD_RD_CFG_LO && req_data_byte <= CMD_RD_CFG_HI) begin
         op.cmd = CC_RD_CFG;
      end else if (req_data_byte >= CMD_WR_CFG_LO && req_data_byte <= CMD_WR_CFG_HI) begin
         op.cmd = CC_WR_CFG;
      end else begin
         case (req_data_byte)
            CMD_SELF_TEST:   op.cmd = CC_SELF_TEST;
            CMD_KBD_TEST:    op.cmd = CC_PORT_TEST;
            CMD_AUX_TEST:    op.cmd = CC_PORT_TEST;
            CMD_KBD_DISABLE: op.cmd = CC_SET_KBD_DIS;
            CMD_KBD_ENABLE:  op.cmd = CC_CLR_KBD_DIS;
            CMD_AUX_DISABLE: op.cmd = CC_SET_AUX_DIS;
            CMD_AUX_ENABLE:  op.cmd = CC_CLR_AUX_DIS;
            CMD_RD_INPORT:   op.cmd = CC_RD_INPORT;
            CMD_RD_OUTPORT:  op.cmd = CC_RD_OUTPORT;
            CMD_WR_OUTPORT:  op.cmd = CC_WR_OUTPORT;
            CMD_WR_AUX:      op.cmd = CC_WR_AUX;
            default:         op.cmd = CC_IGNORE;
         endcase
      end

      // keyboard command class
      case (req_data_byte)
         KBD_CODE_RESET:   op.kbd = KC_RESET;
         KBD_CODE_IDENT:   op.kbd = KC_IDENT;
         KBD_CODE_ECHO:    op.kbd = KC_ECHO;
         KBD_CODE_LEDS:    op.kbd = KC_PARAM;
         KBD_CODE_RATE:    op.kbd = KC_PARAM;
         KBD_CODE_SCANSET: op.kbd = KC_PARAM;
         default:          op.kbd = KC_OTHER;
      endcase
   end

endmodule
`default_nettype wire

// File: hw/rtl/ps2kc_queue.sv
`default_nettype none
module ps2kc_queue
   import ps2kc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   output logic        full,
   output logic        valid,
   input  wire logic   pop,
   output op_type      pop_op
);

   op_type     entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full   = (count_ff == 2'd2);
   assign valid  = (count_ff != 2'd0);
   assign pop_op = entry_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/ps2kc_back.sv
`default_nettype none
module ps2kc_back
   import ps2kc_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       op_valid,
   input  wire op_type     op,
   output logic            op_pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_byte,
   output logic            rsp_inject_ok
);

   // ring of a power-of-two size split into four banks, so three
   // consecutive bytes always land in different banks
   localparam int PW        = ($clog2(FIFO_DEPTH) > 3) ? $clog2(FIFO_DEPTH) : 3;
   localparam int RAW       = PW - 2;
   localparam int ROWS      = 2 ** RAW;
   localparam int NUM_BANKS = 4;
   localparam int CW        = $clog2(FIFO_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C     = CW'(FIFO_DEPTH);
   localparam logic [CW-1:0] INJ_LIMIT_C = CW'(FIFO_DEPTH - 4);

   logic [PW-1:0]  head_ff, head_in;
   logic [PW-1:0]  tail_ff, tail_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [7:0]     cfg_ff, cfg_in;
   logic [7:0]     outport_ff, outport_in;
   pend_kind_type  pend_ff, pend_in;
   logic           await_ff, await_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_from_mem_ff;
   logic [1:0]     rsp_bank_ff;
   logic [7:0]     rsp_byte_ff;
   logic           rsp_ok_ff;

   logic           exec;
   logic           pop_byte;
   logic           res_from_mem;
   logic [7:0]     res_byte;
   logic           res_ok;
   logic [7:0]     push_byte [3];
   logic [1:0]     push_req;
   logic [1:0]     push_num;
   logic [CW-1:0]  space;

   logic           bank_we   [NUM_BANKS];
   logic [RAW-1:0] bank_row  [NUM_BANKS];
   logic [7:0]     bank_wdat [NUM_BANKS];
   logic [7:0]     bank_rdat [NUM_BANKS];
   logic [PW-1:0]  push_addr [3];

   // an item runs when the output register is free or being emptied
   assign exec          = op_valid && (!rsp_valid_ff || !rsp_stall);
   assign op_pop        = exec;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_inject_ok = rsp_ok_ff;
   assign rsp_read_byte = rsp_from_mem_ff ? bank_rdat[rsp_bank_ff] : rsp_byte_ff;

   // execute one bus access
   always_comb begin
      cfg_in       = cfg_ff;
      outport_in   = outport_ff;
      pend_in      = pend_ff;
      await_in     = await_ff;
      pop_byte     = 1'b0;
      res_from_mem = 1'b0;
      res_byte     = 8'h00;
      res_ok       = 1'b0;
      push_req     = 2'd0;
      push_byte[0] = RESP_ACK;
      push_byte[1] = RESP_BAT_OK;
      push_byte[2] = RESP_ID_1;

      case (op.kind)
         OP_RD_DATA: begin
            if (count_ff != '0) begin
               pop_byte     = 1'b1;
               res_from_mem = 1'b1;
            end
         end
         OP_RD_STATUS: begin
            res_byte = STATUS_BASE | {7'd0, (count_ff != '0)};
         end
         OP_WR_DATA: begin
            if (pend_ff != PEND_NONE) begin
               // finish the pending controller command
               pend_in = PEND_NONE;
               case (pend_ff)
                  PEND_CFG:     cfg_in = op.data_byte;
                  PEND_OUTPORT: outport_in = op.data_byte;
                  default:      push_req = 2'd1;
               endcase
            end else if (await_ff) begin
               await_in = 1'b0;
               push_req = 2'd1;
            end else begin
               case (op.kbd)
                  KC_RESET: push_req = 2'd2;
                  KC_IDENT: begin
                     push_req     = 2'd3;
                     push_byte[1] = RESP_ID_0;
                  end
                  KC_ECHO: begin
                     push_req     = 2'd1;
                     push_byte[0] = RESP_ECHO;
                  end
                  KC_PARAM: begin
                     await_in = 1'b1;
                     push_req = 2'd1;
                  end
                  default: push_req = 2'd1;
               endcase
            end
         end
         OP_WR_CMD: begin
            case (op.cmd)
               CC_RD_CFG: begin
                  push_req     = 2'd1;
                  push_byte[0] = cfg_ff;
               end
               CC_WR_CFG: pend_in = PEND_CFG;
               CC_SELF_TEST: begin
                  push_req     = 2'd1;
                  push_byte[0] = RESP_SELF_TEST;
               end
               CC_PORT_TEST: begin
                  push_req     = 2'd1;
                  push_byte[0] = RESP_PORT_OK;
               end
               CC_SET_KBD_DIS: cfg_in = cfg_ff | CFG_KBD_DIS;
               CC_CLR_KBD_DIS: cfg_in = cfg_ff & ~CFG_KBD_DIS;
               CC_SET_AUX_DIS: cfg_in = cfg_ff | CFG_AUX_DIS;
               CC_CLR_AUX_DIS: cfg_in = cfg_ff & ~CFG_AUX_DIS;
               CC_RD_INPORT: begin
                  push_req     = 2'd1;
                  push_byte[0] = RESP_INPORT;
               end
               CC_RD_OUTPORT: begin
                  push_req     = 2'd1;
                  push_byte[0] = outport_ff;
               end
               CC_WR_OUTPORT: pend_in = PEND_OUTPORT;
               CC_WR_AUX:     pend_in = PEND_AUX;
               default: ;
            endcase
         end
         OP_INJECT: begin
            if (count_ff <= INJ_LIMIT_C) begin
               push_req     = 2'd2;
               push_byte[0] = op.data_byte;
               push_byte[1] = op.second_byte;
               res_ok       = 1'b1;
            end
         end
         default: ;
      endcase

      if (!exec) begin
         push_req = 2'd0;
         pop_byte = 1'b0;
      end
   end

   // bytes beyond the free space are dropped
   always_comb begin
      space    = DEPTH_C - count_ff;
      push_num = (space < {{(CW-2){1'b0}}, push_req}) ? space[1:0] : push_req;
      tail_in  = tail_ff + PW'(push_num);
      head_in  = head_ff + PW'(pop_byte);
      count_in = count_ff + CW'(push_num) - CW'(pop_byte);
   end

   // steer up to three bytes onto the banks
   always_comb begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         bank_we[b]   = 1'b0;
         bank_row[b]  = '0;
         bank_wdat[b] = 8'h00;
      end
      for (int i = 0; i < 3; i++) begin
         push_addr[i] = tail_ff + PW'(i);
         if (2'(i) < push_num) begin
            bank_we[push_addr[i][1:0]]   = 1'b1;
            bank_row[push_addr[i][1:0]]  = push_addr[i][PW-1:2];
            bank_wdat[push_addr[i][1:0]] = push_byte[i];
         end
      end
   end

   // bank memories with registered read at the head row
   for (genvar gi = 0; gi < NUM_BANKS; gi++) begin : g_bank
      logic [7:0] bank_mem [ROWS];
      logic [7:0] rdat_ff;

      always_ff @(posedge clock) begin
         if (bank_we[gi]) begin
            bank_mem[bank_row[gi]] <= bank_wdat[gi];
         end
         if (exec) begin
            rdat_ff <= bank_mem[head_ff[PW-1:2]];
         end
      end

      assign bank_rdat[gi] = rdat_ff;
   end

   // output register
   assign rsp_valid_in = exec || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_from_mem_ff <= res_from_mem;
         rsp_bank_ff     <= head_ff[1:0];
         rsp_byte_ff     <= res_byte;
         rsp_ok_ff       <= res_ok;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cfg_ff       <= CFG_RESET;
         outport_ff   <= OUTPORT_RESET;
         pend_ff      <= PEND_NONE;
         await_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            cfg_ff     <= cfg_in;
            outport_ff <= outport_in;
            pend_ff    <= pend_in;
            await_ff   <= await_in;
         end
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/ps2_keyboard_controller_stub_core.sv
// PS/2 controller with an attached keyboard that never sends keys.
// Request channel (req_*): one bus access per beat: data read, status
// read, data write, command write, or injection of a make/break pair.
// Response channel (rsp_*): exactly one beat per request, in order, with
// the read byte (0 for non-reads) and the injection accept flag.
// A front decoder classifies each request into a two-entry queue; the back
// end runs it against the controller state and the response byte ring.
// An accepted request is held in the queue, and its response is registered
// in the output register that drives rsp_valid. Throughput: one request per
// cycle unless the receiver stalls; up to three bytes enter the ring in one
// cycle through four interleaved banks, each with one write and one read.
// When the receiver stalls, the response holds in the output register, the
// back end stops, the queue fills and req_stall rises once two requests wait.
// Reset clears the ring, restores configuration 0x47 and output port 0xCF,
// and drops any pending command; no clearing pass is needed.
`default_nettype none
module ps2_keyboard_controller_stub_core
   import ps2kc_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_type,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [7:0] req_second_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_byte,
   output logic            rsp_inject_ok
);

   op_type front_op;
   op_type back_op;
   logic   q_full;
   logic   q_valid;
   logic   q_pop;
   logic   q_push;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // request classification
   ps2kc_front u_front (
      .req_type        (req_type),
      .req_data_byte   (req_data_byte),
      .req_second_byte (req_second_byte),
      .op              (front_op)
   );

   // decoupling queue
   ps2kc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (front_op),
      .full    (q_full),
      .valid   (q_valid),
      .pop     (q_pop),
      .pop_op  (back_op)
   );

   // execution and response ring
   ps2kc_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .op_valid      (q_valid),
      .op            (back_op),
      .op_pop        (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_byte (rsp_read_byte),
      .rsp_inject_ok (rsp_inject_ok)
   );

endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
   import ps2kc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH   = 16;
   localparam int INJECT_LIMIT = RING_DEPTH - 4;
   localparam int HOLD_CYCLES  = 120;
   localparam int PHASE_BEATS  = 218;
   localparam int HOLD_BEATS   = 20;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   // one bus access, with an optional hand-written reply
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] d;
      logic [7:0] s;
      logic       typed;
      logic [7:0] exp_byte;
      logic       exp_ok;
   } access_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       inject_ok;
   } reply_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_type = '0;
   logic [7:0] req_data_byte = '0;
   logic [7:0] req_second_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_byte;
   logic       rsp_inject_ok;

   // controller state as the predictor sees it
   logic [7:0]    ring_q [RING_DEPTH];
   logic [3:0]    rd_ptr = '0;
   logic [3:0]    wr_ptr = '0;
   int            fill = 0;
   logic [7:0]    cfg_q = CFG_RESET;
   logic [7:0]    outport_q = OUTPORT_RESET;
   pend_kind_type pend_q = PEND_NONE;
   logic          param_wait_q = 1'b0;

   access_type accesses_offered [$];
   access_type upcoming [$];
   reply_type  replies_due [$];

   int   err_count = 0;
   int   reply_count = 0;
   int   cycle_count = 0;
   int   send_pct = 0;
   int   stall_pct = 0;
   int   hold_left = 0;
   logic hold_req = 1'b0;
   logic hold_seen = 1'b0;

   int phase_send  [4] = '{0, 63, 0, 27};
   int phase_stall [4] = '{0, 0, 63, 27};

   logic [7:0] plain_cmds [10] = '{CMD_SELF_TEST, CMD_KBD_TEST, CMD_AUX_TEST,
      CMD_KBD_DISABLE, CMD_KBD_ENABLE, CMD_AUX_DISABLE, CMD_AUX_ENABLE,
      CMD_RD_INPORT, CMD_RD_OUTPORT, CMD_RD_CFG_LO};
   logic [7:0] kbd_cmds [6] = '{KBD_CODE_RESET, KBD_CODE_IDENT, KBD_CODE_ECHO,
      KBD_CODE_LEDS, KBD_CODE_RATE, KBD_CODE_SCANSET};

   // directed opening: reset values, every port and many commands, full ring
   access_type directed_steps [25] = '{
      '{REQ_RD_STATUS, 8'h00, 8'h00, 1'b1, STATUS_BASE, 1'b0},
      '{REQ_RD_DATA, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
      '{REQ_UNUSED_HI, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
      '{REQ_WR_CMD, CMD_RD_CFG_HI, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_CMD, CMD_RD_OUTPORT, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_CMD, CMD_WR_CFG_LO, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_DATA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_CMD, CMD_WR_OUTPORT, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_DATA, 8'hFF, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_CMD, CMD_WR_AUX, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_DATA, 8'h12, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_CMD, CMD_SELF_TEST, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_CMD, CMD_RD_INPORT, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_DATA, KBD_CODE_IDENT, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_DATA, KBD_CODE_RESET, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_RD_STATUS, 8'h00, 8'h00, 1'b1, STATUS_BASE | 8'h01, 1'b0},
      '{REQ_INJECT, 8'h00, 8'hFF, 1'b1, 8'h00, 1'b1},
      '{REQ_INJECT, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b1},
      '{REQ_INJECT, 8'h5A, 8'hA5, 1'b1, 8'h00, 1'b0},
      '{REQ_WR_DATA, KBD_CODE_ECHO, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_DATA, KBD_CODE_LEDS, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_DATA, 8'h55, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_CMD, CMD_KBD_DISABLE, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_WR_CMD, CMD_RD_CFG_LO, 8'h00, 1'b0, 8'h00, 1'b0},
      '{REQ_RD_DATA, 8'h00, 8'h00, 1'b1, CFG_RESET, 1'b0}
   };

   ps2_keyboard_controller_stub_core #(
      .FIFO_DEPTH(RING_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_data_byte  (req_data_byte),
      .req_second_byte(req_second_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_inject_ok  (rsp_inject_ok)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      foreach (ring_q[i]) ring_q[i] = '0;
   end

   // bytes queued on a full ring are lost
   function automatic void ring_push(logic [7:0] b);
      if (fill < RING_DEPTH) begin
         ring_q[wr_ptr] = b;
         wr_ptr = wr_ptr + 4'd1;
         fill++;
      end
   endfunction

   function automatic reply_type predict_reply(logic [2:0] kind, logic [7:0] d, logic [7:0] s);
      reply_type r;
      r = '0;
      case (kind)
         REQ_RD_DATA: begin
            if (fill != 0) begin
               r.read_byte = ring_q[rd_ptr];
               rd_ptr = rd_ptr + 4'd1;
               fill--;
            end
         end
         REQ_RD_STATUS: begin
            r.read_byte = STATUS_BASE | ((fill != 0) ? 8'h01 : 8'h00);
         end
         REQ_WR_DATA: begin
            // pending controller command wins, then a keyboard parameter
            if (pend_q != PEND_NONE) begin
               case (pend_q)
                  PEND_CFG:     cfg_q = d;
                  PEND_OUTPORT: outport_q = d;
                  default:      ring_push(RESP_ACK);
               endcase
               pend_q = PEND_NONE;
            end else if (param_wait_q) begin
               param_wait_q = 1'b0;
               ring_push(RESP_ACK);
            end else begin
               case (d)
                  KBD_CODE_RESET: begin
                     ring_push(RESP_ACK);
                     ring_push(RESP_BAT_OK);
                  end
                  KBD_CODE_IDENT: begin
                     ring_push(RESP_ACK);
                     ring_push(RESP_ID_0);
                     ring_push(RESP_ID_1);
                  end
                  KBD_CODE_ECHO: ring_push(RESP_ECHO);
                  KBD_CODE_LEDS, KBD_CODE_RATE, KBD_CODE_SCANSET: begin
                     param_wait_q = 1'b1;
                     ring_push(RESP_ACK);
                  end
                  default: ring_push(RESP_ACK);
               endcase
            end
         end
         REQ_WR_CMD: begin
            if (d >= CMD_RD_CFG_LO && d <= CMD_RD_CFG_HI) begin
               ring_push(cfg_q);
            end else if (d >= CMD_WR_CFG_LO && d <= CMD_WR_CFG_HI) begin
               pend_q = PEND_CFG;
            end else begin
               case (d)
                  CMD_SELF_TEST:               ring_push(RESP_SELF_TEST);
                  CMD_KBD_TEST, CMD_AUX_TEST:  ring_push(RESP_PORT_OK);
                  CMD_KBD_DISABLE:             cfg_q = cfg_q | CFG_KBD_DIS;
                  CMD_KBD_ENABLE:              cfg_q = cfg_q & ~CFG_KBD_DIS;
                  CMD_AUX_DISABLE:             cfg_q = cfg_q | CFG_AUX_DIS;
                  CMD_AUX_ENABLE:              cfg_q = cfg_q & ~CFG_AUX_DIS;
                  CMD_RD_INPORT:               ring_push(RESP_INPORT);
                  CMD_RD_OUTPORT:              ring_push(outport_q);
                  CMD_WR_OUTPORT:              pend_q = PEND_OUTPORT;
                  CMD_WR_AUX:                  pend_q = PEND_AUX;
                  default: ;
               endcase
            end
         end
         REQ_INJECT: begin
            if (fill <= INJECT_LIMIT) begin
               ring_push(d);
               ring_push(s);
               r.inject_ok = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic access_type make_access(logic [2:0] kind, logic [7:0] d);
      access_type a;
      a = '0;
      a.kind = kind;
      a.d = d;
      a.s = 8'($urandom);
      return a;
   endfunction

   // random traffic; command and parameter bytes are mostly followed by data
   task automatic plan_burst();
      int pick;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         upcoming.push_back(make_access(REQ_RD_DATA, 8'($urandom)));
      end else if (pick < 46) begin
         upcoming.push_back(make_access(REQ_RD_STATUS, 8'($urandom)));
      end else if (pick < 52) begin
         repeat ($urandom_range(8, 18))
            upcoming.push_back(make_access(REQ_RD_DATA, 8'($urandom)));
      end else if (pick < 62) begin
         case ($urandom_range(0, 2))
            0:       c = CMD_WR_CFG_LO + 8'($urandom_range(0, 31));
            1:       c = CMD_WR_OUTPORT;
            default: c = CMD_WR_AUX;
         endcase
         upcoming.push_back(make_access(REQ_WR_CMD, c));
         if ($urandom_range(0, 4) != 0)
            upcoming.push_back(make_access(REQ_WR_DATA, 8'($urandom)));
      end else if (pick < 70) begin
         case ($urandom_range(0, 4))
            0, 1:    c = plain_cmds[$urandom_range(0, 9)];
            2:       c = CMD_RD_CFG_LO + 8'($urandom_range(0, 31));
            default: c = 8'($urandom);
         endcase
         upcoming.push_back(make_access(REQ_WR_CMD, c));
      end else if (pick < 82) begin
         if ($urandom_range(0, 3) == 0)
            c = 8'($urandom);
         else
            c = kbd_cmds[$urandom_range(0, 5)];
         upcoming.push_back(make_access(REQ_WR_DATA, c));
         if ((c == KBD_CODE_LEDS || c == KBD_CODE_RATE || c == KBD_CODE_SCANSET)
             && $urandom_range(0, 4) != 0)
            upcoming.push_back(make_access(REQ_WR_DATA, 8'($urandom)));
      end else if (pick < 95) begin
         upcoming.push_back(make_access(REQ_INJECT, 8'($urandom)));
      end else begin
         upcoming.push_back(make_access(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)),
                                        8'($urandom)));
      end
   endtask

   // offer one beat, with a random gap in front, and wait for acceptance
   task automatic send_access(access_type a);
      if ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_pct);
      end
      accesses_offered.push_back(a);
      req_valid       <= 1'b1;
      req_type        <= a.kind;
      req_data_byte   <= a.d;
      req_second_byte <= a.s;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_replies_done();
      do @(posedge clock); while (replies_due.size() != 0);
   endtask

   task automatic flag_error(string msg);
      err_count++;
      if (err_count <= 10) $display("%s", msg);
   endtask

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      access_type a;
      reply_type  want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            a = accesses_offered.pop_front();
            want = predict_reply(req_type, req_data_byte, req_second_byte);
            if (a.typed) begin
               want.read_byte = a.exp_byte;
               want.inject_ok = a.exp_ok;
            end
            replies_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               flag_error($sformatf("reply %0d: unexpected beat, read_byte %02h inject_ok %0b",
                                    reply_count, rsp_read_byte, rsp_inject_ok));
            end else begin
               want = replies_due.pop_front();
               if (rsp_read_byte !== want.read_byte)
                  flag_error($sformatf("reply %0d read_byte: expected %02h, got %02h",
                                       reply_count, want.read_byte, rsp_read_byte));
               if (rsp_inject_ok !== want.inject_ok)
                  flag_error($sformatf("reply %0d inject_ok: expected %0b, got %0b",
                                       reply_count, want.inject_ok, rsp_inject_ok));
            end
            reply_count++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_steps[i]) send_access(directed_steps[i]);

      // random phases, each ending with a long hold-off and a full drain
      for (int phase = 0; phase < 4; phase++) begin
         send_pct  = phase_send[phase];
         stall_pct = phase_stall[phase];
         for (n = 0; n < PHASE_BEATS; n++) begin
            if (upcoming.size() == 0) plan_burst();
            send_access(upcoming.pop_front());
         end
         hold_req <= ~hold_req;
         send_pct = 0;
         for (n = 0; n < HOLD_BEATS; n++) begin
            if (upcoming.size() == 0) plan_burst();
            send_access(upcoming.pop_front());
         end
         req_valid <= 1'b0;
         wait_replies_done();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
